[design/tod_elapsed_seconds_unit_defines.svh]
// ---------------------------------------------------------------------------
// tod_elapsed_seconds_unit_defines
// Assertion macros shared by the checker of the elapsed seconds unit.
// ---------------------------------------------------------------------------
`ifndef TOD_ELAPSED_SECONDS_UNIT_DEFINES_SVH
`define TOD_ELAPSED_SECONDS_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define TES_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tod elapsed seconds check failed");

// next-cycle implication, disabled while reset is asserted
`define TES_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tod elapsed seconds check failed");

`endif

[design/tes_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tes_pkg
// Constants and helper functions of the elapsed seconds unit.
// ---------------------------------------------------------------------------
package tes_pkg;

  // pipeline depth from accepted word to result strobe
  localparam int unsigned Latency = 4;

  // field widths
  localparam int unsigned HourW = 7;   // 24-hour value, up to 97
  localparam int unsigned BcdW  = 8;   // two-digit value, up to 165
  localparam int unsigned SodW  = 19;  // seconds of day, up to 359265
  localparam int unsigned DiffW = SodW + 1;
  localparam int unsigned WrapW = DiffW + 1;
  localparam int unsigned OutW  = 16;

  // time constants
  localparam logic [SodW-1:0]  HourSecs    = SodW'(3600);
  localparam logic [SodW-1:0]  MinSecs     = SodW'(60);
  localparam logic [WrapW-1:0] DaySeconds  = WrapW'(86400);
  localparam logic [OutW-1:0]  ElapsedMax  = 16'hFFFF;
  localparam logic [HourW-1:0] NoonHour    = 7'd12;
  localparam logic [HourW-1:0] PmOffset    = 7'd12;
  localparam int unsigned      PmBit       = 7;

  typedef logic [HourW-1:0] hour_t;
  typedef logic [BcdW-1:0]  bcd_t;
  typedef logic [SodW-1:0]  sod_t;

  // two bcd digits to binary, digits above nine used as they are
  function automatic bcd_t bcd_value(input logic [7:0] b);
    return bcd_t'({4'b0, b[7:4]} * 8'd10 + {4'b0, b[3:0]});
  endfunction

  // 12-hour bcd byte with pm flag to 24-hour binary hour
  function automatic hour_t hour_24(input logic [7:0] hb);
    hour_t h;
    h = hour_t'({4'b0, hb[6:4]} * 7'd10 + {3'b0, hb[3:0]});
    if (h == NoonHour) begin
      h = hb[PmBit] ? NoonHour : '0;
    end else if (hb[PmBit]) begin
      h = h + PmOffset;
    end
    return h;
  endfunction

endpackage

[design/tod_elapsed_seconds_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tod_elapsed_seconds_unit
// Elapsed seconds between two 12-hour bcd times of day, four-stage pipeline.
// ---------------------------------------------------------------------------
// Usage:
//   A word (start and end time, each hours/minutes/seconds as raw bcd bytes,
//   pm flag in bit 7 of hours) is taken at a rising edge with start_i high
//   and busy_o low. busy_o is always low, so a new word may enter every
//   cycle; throughput is one word per clock.
//   When a word's result leaves the last stage, done_o is high for one cycle and
//   elapsed_seconds_o carries its result. Stages: bcd decode and 12/24-hour
//   fix, seconds-of-day multiply-add, end minus start, midnight wrap and
//   saturation to 65535. Words leave in the order they came in.
//   The receiver cannot stall; every result is shown once, for one cycle.
//   Reset (rst_ni low, asynchronous) clears the stage valid bits, so words
//   in flight are dropped and done_o stays low until new words arrive.
// ---------------------------------------------------------------------------
module tod_elapsed_seconds_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [7:0]  start_hours_i,
  input  logic [7:0]  start_minutes_i,
  input  logic [7:0]  start_seconds_i,
  input  logic [7:0]  end_hours_i,
  input  logic [7:0]  end_minutes_i,
  input  logic [7:0]  end_seconds_i,
  output logic        done_o,
  output logic [15:0] elapsed_seconds_o
);

  // pipeline never stalls
  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  // stage valid bits
  logic [tes_pkg::Latency-1:0] vld_d, vld_q;

  assign vld_d = {vld_q[tes_pkg::Latency-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // stage 1: bcd decode and 12/24-hour fix
  tes_pkg::hour_t st_h_q, en_h_q;
  tes_pkg::bcd_t  st_m_q, st_s_q, en_m_q, en_s_q;

  always_ff @(posedge clk_i) begin
    st_h_q <= tes_pkg::hour_24(start_hours_i);
    st_m_q <= tes_pkg::bcd_value(start_minutes_i);
    st_s_q <= tes_pkg::bcd_value(start_seconds_i);
    en_h_q <= tes_pkg::hour_24(end_hours_i);
    en_m_q <= tes_pkg::bcd_value(end_minutes_i);
    en_s_q <= tes_pkg::bcd_value(end_seconds_i);
  end

  // stage 2: seconds since midnight
  tes_pkg::sod_t st_sod_d, en_sod_d, st_sod_q, en_sod_q;

  always_comb begin
    st_sod_d = {12'b0, st_h_q} * tes_pkg::HourSecs + {11'b0, st_m_q} * tes_pkg::MinSecs
             + {11'b0, st_s_q};
    en_sod_d = {12'b0, en_h_q} * tes_pkg::HourSecs + {11'b0, en_m_q} * tes_pkg::MinSecs
             + {11'b0, en_s_q};
  end

  always_ff @(posedge clk_i) begin
    st_sod_q <= st_sod_d;
    en_sod_q <= en_sod_d;
  end

  // stage 3: signed difference
  logic [tes_pkg::DiffW-1:0] diff_d, diff_q;

  assign diff_d = {1'b0, en_sod_q} - {1'b0, st_sod_q};

  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
  end

  // stage 4: midnight wrap and saturation
  logic [tes_pkg::WrapW-1:0] wrap;
  logic [15:0]               elapsed_d, elapsed_q;

  always_comb begin
    wrap = {diff_q[tes_pkg::DiffW-1], diff_q};
    if (diff_q[tes_pkg::DiffW-1]) begin
      wrap = wrap + tes_pkg::DaySeconds;
    end
    if (wrap[tes_pkg::WrapW-1] || (|wrap[tes_pkg::WrapW-2:tes_pkg::OutW])) begin
      elapsed_d = tes_pkg::ElapsedMax;
    end else begin
      elapsed_d = wrap[tes_pkg::OutW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    elapsed_q <= elapsed_d;
  end

  assign done_o            = vld_q[tes_pkg::Latency-1];
  assign elapsed_seconds_o = elapsed_q;

endmodule

[design/tes_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tes_checker
// Port-level checks of the elapsed seconds unit, bound to the unit module.
// ---------------------------------------------------------------------------
`include "tod_elapsed_seconds_unit_defines.svh"

module tes_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic [7:0]  start_hours_i,
  input logic [7:0]  start_minutes_i,
  input logic [7:0]  start_seconds_i,
  input logic [7:0]  end_hours_i,
  input logic [7:0]  end_minutes_i,
  input logic [7:0]  end_seconds_i,
  input logic        done_o,
  input logic [15:0] elapsed_seconds_o
);

  logic accept;
  logic same_time;
  assign accept    = start_i && !busy_o;
  assign same_time = (start_hours_i == end_hours_i) && (start_minutes_i == end_minutes_i)
                  && (start_seconds_i == end_seconds_i);

  // the unit never holds off a word
  `TES_ASSERT_NXT(a_never_busy, clk_i, rst_ni, 1'b1, !busy_o)

  // every result strobe belongs to a word that has run through the pipeline
  `TES_ASSERT_IMP(a_done_has_word, clk_i, rst_ni, done_o, $past(accept, tes_pkg::Latency))

  // every word taken out of reset gives its strobe once it has run through the pipeline
  `TES_ASSERT_IMP(a_word_gives_done, clk_i, rst_ni,
                  $past(accept, tes_pkg::Latency) && $past(rst_ni, 1) && $past(rst_ni, 2)
                  && $past(rst_ni, 3) && $past(rst_ni, 4), done_o)

  // equal start and end times give zero elapsed seconds
  `TES_ASSERT_IMP(a_same_time_zero, clk_i, rst_ni,
                  done_o && $past(same_time, tes_pkg::Latency), elapsed_seconds_o == 16'd0)

endmodule

bind tod_elapsed_seconds_unit tes_checker u_tes_checker (.*);

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the elapsed seconds unit.
// ---------------------------------------------------------------------------
// Directed words hit the field extremes, the 12 AM / 12 PM rules, hour zero,
// the midnight wrap, saturation and digits above nine. Random words follow:
// mostly legal 12-hour times, some near each other, the rest raw bytes.
// Idle bursts on the sender side; results are checked in order against a
// behavioral model of the conversion.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int DaySecs     = 86400;
  localparam int SatValue    = 65535;
  localparam int CycleLimit  = 200000;
  localparam int DrainLimit  = 64 * tes_pkg::Latency;
  localparam int RandomWords = 500;
  localparam int BurstWords  = 100;
  localparam int MaxReports  = 10;

  typedef struct packed {
    logic [7:0] sh;
    logic [7:0] sm;
    logic [7:0] ss;
    logic [7:0] eh;
    logic [7:0] em;
    logic [7:0] es;
  } tod_word_t;

  typedef struct {
    tod_word_t   word;
    logic [15:0] elapsed;
  } elapsed_entry_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        start_i         = 1'b0;
  logic [7:0]  start_hours_i   = 8'h00;
  logic [7:0]  start_minutes_i = 8'h00;
  logic [7:0]  start_seconds_i = 8'h00;
  logic [7:0]  end_hours_i     = 8'h00;
  logic [7:0]  end_minutes_i   = 8'h00;
  logic [7:0]  end_seconds_i   = 8'h00;
  logic        busy_o;
  logic        done_o;
  logic [15:0] elapsed_seconds_o;

  elapsed_entry_t elapsed_expected_q[$];
  int n_words_sent   = 0;
  int n_results_seen = 0;
  int n_errors       = 0;
  int cycle_count    = 0;

  tod_elapsed_seconds_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .start_hours_i     (start_hours_i),
    .start_minutes_i   (start_minutes_i),
    .start_seconds_i   (start_seconds_i),
    .end_hours_i       (end_hours_i),
    .end_minutes_i     (end_minutes_i),
    .end_seconds_i     (end_seconds_i),
    .done_o            (done_o),
    .elapsed_seconds_o (elapsed_seconds_o)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb_top: cycle limit reached with %0d results pending",
               elapsed_expected_q.size());
      $display("tb_top: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // behavioral model
  // ---------------------------------------------------------------------------

  // two raw digits, nibbles above nine taken at face value
  function automatic int digits_value(logic [7:0] b);
    return b[7:4] * 10 + b[3:0];
  endfunction

  // 12-hour bcd time to seconds since midnight
  function automatic int seconds_since_midnight(logic [7:0] hb, logic [7:0] mb,
                                                logic [7:0] sb);
    int h;
    h = digits_value({1'b0, hb[6:0]});
    if (h == 12) begin
      h = hb[7] ? 12 : 0;
    end else if (hb[7]) begin
      h = h + 12;
    end
    return h * 3600 + digits_value(mb) * 60 + digits_value(sb);
  endfunction

  // end minus start with midnight wrap and saturation
  function automatic logic [15:0] predict_elapsed(tod_word_t w);
    int d;
    d = seconds_since_midnight(w.eh, w.em, w.es) - seconds_since_midnight(w.sh, w.sm, w.ss);
    if (d < 0) d = d + DaySecs;
    if (d < 0 || d > SatValue) d = SatValue;
    return d[15:0];
  endfunction

  // seconds since midnight (legal range) to 12-hour bcd bytes
  function automatic logic [23:0] tod_bytes_of(int s);
    int h24;
    int h12;
    int m;
    int sec;
    h24 = s / 3600;
    m   = (s / 60) % 60;
    sec = s % 60;
    h12 = h24 % 12;
    if (h12 == 0) h12 = 12;
    return {h24 >= 12, 3'(h12 / 10), 4'(h12 % 10), 4'(m / 10), 4'(m % 10),
            4'(sec / 10), 4'(sec % 10)};
  endfunction

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------

  // compare each strobed result with the oldest expectation
  always @(posedge clk_i) begin
    elapsed_entry_t e;
    if (rst_ni && done_o) begin
      n_results_seen++;
      if (elapsed_expected_q.size() == 0) begin
        if (n_errors < MaxReports)
          $display("tb_top: result %0d with no word outstanding", elapsed_seconds_o);
        n_errors++;
      end else begin
        e = elapsed_expected_q.pop_front();
        if (elapsed_seconds_o !== e.elapsed) begin
          if (n_errors < MaxReports)
            $display("tb_top: mismatch for %h %h %h -> %h %h %h: expected %0d, got %0d",
                     e.word.sh, e.word.sm, e.word.ss, e.word.eh, e.word.em, e.word.es,
                     e.elapsed, elapsed_seconds_o);
          n_errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // present one word and hold it until taken; called right after a rising edge
  task automatic send_word(tod_word_t w);
    elapsed_entry_t e;
    start_i         <= 1'b1;
    start_hours_i   <= w.sh;
    start_minutes_i <= w.sm;
    start_seconds_i <= w.ss;
    end_hours_i     <= w.eh;
    end_minutes_i   <= w.em;
    end_seconds_i   <= w.es;
    do @(posedge clk_i); while (busy_o);
    e.word    = w;
    e.elapsed = predict_elapsed(w);
    elapsed_expected_q.push_back(e);
    n_words_sent++;
  endtask

  // drop start and put junk on the fields while the sender idles
  task automatic idle_for(int n);
    start_i         <= 1'b0;
    start_hours_i   <= 8'($urandom);
    start_minutes_i <= 8'($urandom);
    start_seconds_i <= 8'($urandom);
    end_hours_i     <= 8'($urandom);
    end_minutes_i   <= 8'($urandom);
    end_seconds_i   <= 8'($urandom);
    repeat (n) @(posedge clk_i);
  endtask

  // hold off until every outstanding result has come back or the drain limit runs out
  task automatic drain_results();
    int waited;
    waited = 0;
    idle_for(1);
    while (elapsed_expected_q.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (elapsed_expected_q.size() != 0) begin
      $display("tb_top: %0d results never arrived", elapsed_expected_q.size());
      n_errors += elapsed_expected_q.size();
      elapsed_expected_q.delete();
    end
  endtask

  // random word: legal times, nearby legal times, or raw bytes
  function automatic tod_word_t random_word();
    int s0;
    int s1;
    int pick;
    pick = $urandom_range(0, 9);
    s0   = $urandom_range(0, DaySecs - 1);
    if (pick < 2) return tod_word_t'(48'({$urandom, $urandom}));
    if (pick < 5) s1 = (s0 + $urandom_range(0, 300)) % DaySecs;
    else if (pick < 6) s1 = (s0 + DaySecs - $urandom_range(0, 300)) % DaySecs;
    else s1 = $urandom_range(0, DaySecs - 1);
    return {tod_bytes_of(s0), tod_bytes_of(s1)};
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_field_extremes();
    send_word({8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
    send_word({8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    // start far beyond one day: still negative after the wrap
    send_word({8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00});
    send_word({8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF});
    idle_for(3);
    send_word({8'h7F, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00});
  endtask

  task automatic test_twelve_hour_rules();
    // 12 AM is midnight, 12 PM is noon, other PM hours gain twelve
    send_word({8'h12, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00});
    send_word({8'h92, 8'h00, 8'h00, 8'h81, 8'h00, 8'h00});
    send_word({8'h12, 8'h00, 8'h00, 8'h92, 8'h00, 8'h00});
    // hour zero, AM and PM
    send_word({8'h00, 8'h00, 8'h00, 8'h80, 8'h00, 8'h00});
    // hour digits 0x0C read as twelve
    send_word({8'h0C, 8'h00, 8'h00, 8'h8C, 8'h00, 8'h00});
    send_word({8'h91, 8'h30, 8'h00, 8'h92, 8'h00, 8'h00});
  endtask

  task automatic test_midnight_wrap();
    send_word({8'h91, 8'h59, 8'h59, 8'h12, 8'h00, 8'h01});
    send_word({8'h01, 8'h00, 8'h01, 8'h01, 8'h00, 8'h00});
    send_word({8'h86, 8'h00, 8'h00, 8'h12, 8'h00, 8'h00});
    idle_for(2);
    send_word({8'h85, 8'h47, 8'h44, 8'h12, 8'h00, 8'h00});
  endtask

  task automatic test_saturation();
    // just below, at and just above the ceiling
    send_word({8'h00, 8'h00, 8'h00, 8'h86, 8'h12, 8'h14});
    send_word({8'h00, 8'h00, 8'h00, 8'h86, 8'h12, 8'h15});
    send_word({8'h00, 8'h00, 8'h00, 8'h86, 8'h12, 8'h16});
    send_word({8'h12, 8'h00, 8'h00, 8'h91, 8'h59, 8'h59});
  endtask

  task automatic test_invalid_digits();
    send_word({8'h00, 8'h00, 8'h00, 8'h00, 8'hFA, 8'h0F});
    send_word({8'h3A, 8'hAF, 8'hC9, 8'hBE, 8'h5D, 8'hE2});
    send_word({8'h8F, 8'h9B, 8'h7C, 8'h0F, 8'hF0, 8'hAA});
  endtask

  task automatic test_random_words(int count);
    bit quiet_stretch;
    quiet_stretch = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) quiet_stretch = ($urandom_range(0, 3) == 0);
      if (i == count / 2) drain_results();
      if (!quiet_stretch && $urandom_range(0, 3) == 0) idle_for($urandom_range(1, 10));
      send_word(random_word());
    end
  endtask

  // last part: one word per cycle, no gaps
  task automatic test_back_to_back(int count);
    for (int i = 0; i < count; i++) send_word(random_word());
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_twelve_hour_rules();
    drain_results();
    test_midnight_wrap();
    test_saturation();
    test_invalid_digits();
    drain_results();
    test_random_words(RandomWords);
    test_back_to_back(BurstWords);

    drain_results();
    repeat (tes_pkg::Latency + 4) @(posedge clk_i);

    $display("tb_top: %0d words sent, %0d results checked, %0d errors",
             n_words_sent, n_results_seen, n_errors);
    $display("tb_top: covered 12-hour rules, midnight wrap, saturation, bad digits");
    if (n_errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
